### hw/rtl/vlss_pkg.sv
// Package: shared constants and register map for the video line slot sequencer.
`timescale 1ns / 1ps

package vlss_pkg;

    // Ring and transfer sizing
    localparam int SLOTS_DEFAULT = 3;
    localparam logic [11:0] HEADER_WORDS = 12'd7;
    localparam logic [11:0] BLANK_WORDS  = 12'd6;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_FRONT_PORCH = 3'd0;
    localparam logic [2:0] REG_SYNC        = 3'd1;
    localparam logic [2:0] REG_BACK_PORCH  = 3'd2;
    localparam logic [2:0] REG_ACTIVE      = 3'd3;
    localparam logic [2:0] REG_WIDTH       = 3'd4;
    localparam logic [2:0] REG_BLINK       = 3'd5;

    // Register reset values
    localparam logic [9:0]  FRONT_PORCH_RESET = 10'd10;
    localparam logic [9:0]  SYNC_RESET        = 10'd2;
    localparam logic [9:0]  BACK_PORCH_RESET  = 10'd33;
    localparam logic [10:0] ACTIVE_RESET      = 11'd480;
    localparam logic [11:0] WIDTH_RESET       = 12'd640;
    localparam logic [15:0] BLINK_RESET       = 16'd60;

    // Line classification codes
    typedef enum logic [1:0] {
        KIND_VSYNC  = 2'd0,
        KIND_BLANK  = 2'd1,
        KIND_ACTIVE = 2'd2
    } line_kind_t;

endpackage

### hw/rtl/video_line_slot_sequencer_core.sv
// Top level: vertical timing sequencer for a ring of line buffers.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid/in_ready, line_done) carries one request per
//   finished line transfer. A request with line_done high produces one
//   result; one with line_done low is taken and dropped.
//   Output channel (out_valid/out_ready) carries the finished and next ring
//   slot, the line class, the transfer length in words, the fill request
//   with its line number, the frame-start pulse and the blink level.
//   A result is in the output register the cycle after its request is
//   taken. Throughput is one request per cycle while the receiver does not
//   stall; the only storage between the sides is the single output register.
//   When the receiver stalls, the result holds; in_ready is high only while
//   the output register is empty or is being emptied in the same cycle.
//   Reset loads the timing registers with their defaults, sets the slot to 0,
//   the scanline to SLOTS-1, clears the frame phase and blink level and
//   empties the output register.
//   Timing registers sit on an APB port (byte address 4*index, pready tied
//   high) and are to be written only while the block is idle.
module video_line_slot_sequencer_core #(
    parameter int SLOTS = vlss_pkg::SLOTS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        line_done,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  finished_slot,
    output logic [1:0]  next_slot,
    output logic [1:0]  line_kind,
    output logic [11:0] transfer_words,
    output logic        fill_request,
    output logic [10:0] fill_line,
    output logic        frame_start,
    output logic        blink_level
);

    // Configuration registers
    logic [9:0]  front_porch_reg;
    logic [9:0]  sync_reg;
    logic [9:0]  back_porch_reg;
    logic [10:0] active_reg;
    logic [11:0] width_reg;
    logic [15:0] blink_period_reg;

    // Sequencer state
    logic [1:0]  slot_index_reg;
    logic [12:0] scanline_reg;
    logic [15:0] frame_phase_reg;
    logic        blink_state_reg;

    // Output register
    logic        out_valid_reg;
    logic [1:0]  finished_slot_reg;
    logic [1:0]  next_slot_reg;
    vlss_pkg::line_kind_t line_kind_reg;
    logic [11:0] transfer_words_reg;
    logic        fill_request_reg;
    logic [10:0] fill_line_reg;
    logic        frame_start_reg;

    // Next values
    logic [1:0]  slot_index_next;
    logic [12:0] scanline_next;
    logic [15:0] frame_phase_next;
    logic        blink_state_next;
    vlss_pkg::line_kind_t kind_next;
    logic [11:0] words_next;
    logic        fill_next;
    logic [10:0] fill_line_next;
    logic        wrap_next;

    logic        cfg_write;
    logic        in_take;
    logic        step;
    logic [10:0] sync_end;
    logic [11:0] blank_end;
    logic [12:0] total;
    logic [12:0] scan_inc;
    logic [12:0] scan_rel;
    logic [15:0] phase_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_take   = in_valid && in_ready;
    assign step      = in_take && line_done;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_porch_reg  <= vlss_pkg::FRONT_PORCH_RESET;
            sync_reg         <= vlss_pkg::SYNC_RESET;
            back_porch_reg   <= vlss_pkg::BACK_PORCH_RESET;
            active_reg       <= vlss_pkg::ACTIVE_RESET;
            width_reg        <= vlss_pkg::WIDTH_RESET;
            blink_period_reg <= vlss_pkg::BLINK_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                vlss_pkg::REG_FRONT_PORCH: front_porch_reg  <= pwdata[9:0];
                vlss_pkg::REG_SYNC:        sync_reg         <= pwdata[9:0];
                vlss_pkg::REG_BACK_PORCH:  back_porch_reg   <= pwdata[9:0];
                vlss_pkg::REG_ACTIVE:      active_reg       <= pwdata[10:0];
                vlss_pkg::REG_WIDTH:       width_reg        <= pwdata[11:0];
                vlss_pkg::REG_BLINK:       blink_period_reg <= pwdata[15:0];
                default:                   ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (paddr[4:2])
            vlss_pkg::REG_FRONT_PORCH: prdata = {22'd0, front_porch_reg};
            vlss_pkg::REG_SYNC:        prdata = {22'd0, sync_reg};
            vlss_pkg::REG_BACK_PORCH:  prdata = {22'd0, back_porch_reg};
            vlss_pkg::REG_ACTIVE:      prdata = {21'd0, active_reg};
            vlss_pkg::REG_WIDTH:       prdata = {20'd0, width_reg};
            vlss_pkg::REG_BLINK:       prdata = {16'd0, blink_period_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // Frame limits
    assign sync_end  = {1'b0, front_porch_reg} + {1'b0, sync_reg};
    assign blank_end = {1'b0, sync_end} + {2'b00, back_porch_reg};
    assign total     = {1'b0, blank_end} + {2'b00, active_reg};

    // Line classification and transfer length
    assign scan_rel = scanline_reg - {1'b0, blank_end};
    always_comb
    begin
        if ((scanline_reg >= {3'd0, front_porch_reg}) && (scanline_reg < {2'd0, sync_end}))
        begin
            kind_next      = vlss_pkg::KIND_VSYNC;
            words_next     = vlss_pkg::BLANK_WORDS;
            fill_next      = 1'b0;
            fill_line_next = 11'd0;
        end
        else if (scanline_reg < {1'b0, blank_end})
        begin
            kind_next      = vlss_pkg::KIND_BLANK;
            words_next     = vlss_pkg::BLANK_WORDS;
            fill_next      = 1'b0;
            fill_line_next = 11'd0;
        end
        else
        begin
            kind_next      = vlss_pkg::KIND_ACTIVE;
            words_next     = vlss_pkg::HEADER_WORDS + {1'b0, width_reg[11:1]};
            fill_next      = 1'b1;
            fill_line_next = scan_rel[10:0];
        end
    end

    // Slot ring advance
    assign slot_index_next = (slot_index_reg < 2'(SLOTS - 1)) ? slot_index_reg + 2'd1 : 2'd0;

    // Scanline wrap and blink divider
    assign scan_inc  = scanline_reg + 13'd1;
    assign wrap_next = (scan_inc >= total);
    assign phase_inc = frame_phase_reg + 16'd1;
    always_comb
    begin
        scanline_next    = scan_inc;
        frame_phase_next = frame_phase_reg;
        blink_state_next = blink_state_reg;
        if (wrap_next)
        begin
            scanline_next = 13'd0;
            if (phase_inc >= blink_period_reg)
            begin
                frame_phase_next = 16'd0;
                blink_state_next = !blink_state_reg;
            end
            else
            begin
                frame_phase_next = phase_inc;
            end
        end
    end

    // Sequencer state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg  <= 2'd0;
            scanline_reg    <= 13'(SLOTS - 1);
            frame_phase_reg <= 16'd0;
            blink_state_reg <= 1'b0;
        end
        else if (step)
        begin
            slot_index_reg  <= slot_index_next;
            scanline_reg    <= scanline_next;
            frame_phase_reg <= frame_phase_next;
            blink_state_reg <= blink_state_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= step;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            finished_slot_reg  <= slot_index_reg;
            next_slot_reg      <= slot_index_next;
            line_kind_reg      <= kind_next;
            transfer_words_reg <= words_next;
            fill_request_reg   <= fill_next;
            fill_line_reg      <= fill_line_next;
            frame_start_reg    <= wrap_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign finished_slot  = finished_slot_reg;
    assign next_slot      = next_slot_reg;
    assign line_kind      = line_kind_reg;
    assign transfer_words = transfer_words_reg;
    assign fill_request   = fill_request_reg;
    assign fill_line      = fill_line_reg;
    assign frame_start    = frame_start_reg;
    assign blink_level    = blink_state_reg;

`ifndef NO_ASSERTIONS
    // A counted event always lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n) step |=> out_valid)
        else $error("event lost");

    // Frame start pulses exactly when the scanline was forced to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (frame_start == (scanline_reg == 13'd0)))
        else $error("frame start out of step with scanline");

    // Slot index stays inside the ring
    assert property (@(posedge clk) disable iff (!rst_n)
        slot_index_reg < 2'(SLOTS))
        else $error("slot index out of range");

    // Finished and next slot always differ
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_slot != finished_slot))
        else $error("slot ring did not advance");

    // Fill request only on active lines
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fill_request == (line_kind == vlss_pkg::KIND_ACTIVE)))
        else $error("fill request on wrong line class");
`endif

endmodule

### tb/tb.sv
// Testbench for the video line slot sequencer: self-checking stream and register tests.
`timescale 1ns / 1ps

module tb;

    localparam int          NUM_SLOTS   = vlss_pkg::SLOTS_DEFAULT;
    // Addresses past the last timing register; writes there must be dropped
    localparam logic [2:0]  REG_SPARE_A = 3'd6;
    localparam logic [2:0]  REG_SPARE_B = 3'd7;
    localparam int          PHASE_COUNT = 12;
    localparam int          PHASE_LINES = 68;

    // Expected result of one line event
    typedef struct packed {
        logic [1:0]           fin;
        logic [1:0]           nxt;
        vlss_pkg::line_kind_t kind;
        logic [11:0]          words;
        logic                 fill;
        logic [10:0]          fline;
        logic                 fstart;
        logic                 blink;
    } line_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [4:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic        line_done = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [1:0]  finished_slot;
    logic [1:0]  next_slot;
    logic [1:0]  line_kind;
    logic [11:0] transfer_words;
    logic        fill_request;
    logic [10:0] fill_line;
    logic        frame_start;
    logic        blink_level;

    // Timing register shadow
    logic [9:0]  cfg_fp    = vlss_pkg::FRONT_PORCH_RESET;
    logic [9:0]  cfg_sw    = vlss_pkg::SYNC_RESET;
    logic [9:0]  cfg_bp    = vlss_pkg::BACK_PORCH_RESET;
    logic [10:0] cfg_al    = vlss_pkg::ACTIVE_RESET;
    logic [11:0] cfg_aw    = vlss_pkg::WIDTH_RESET;
    logic [15:0] cfg_blink = vlss_pkg::BLINK_RESET;

    // Sequencer state shadow
    logic [1:0]  slot_q    = '0;
    logic [12:0] scan_q    = 13'(NUM_SLOTS - 1);
    logic [15:0] phase_q   = '0;
    logic        blink_q   = 1'b0;

    line_result_t pending_lines[$];
    int           mismatch_count = 0;
    int           send_idle_pct  = 0;
    int           recv_stall_pct = 0;

    video_line_slot_sequencer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .line_done      (line_done),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .finished_slot  (finished_slot),
        .next_slot      (next_slot),
        .line_kind      (line_kind),
        .transfer_words (transfer_words),
        .fill_request   (fill_request),
        .fill_line      (fill_line),
        .frame_start    (frame_start),
        .blink_level    (blink_level)
    );

    always #4 clk = ~clk;

    // Receiver backpressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_value(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    // Advance the shadow sequencer by one line event
    function automatic line_result_t advance_line();
        line_result_t r;
        int unsigned  sync_start, sync_end, blank_end, total, inc;
        sync_start = cfg_fp;
        sync_end   = sync_start + cfg_sw;
        blank_end  = sync_end + cfg_bp;
        total      = blank_end + cfg_al;

        r.fin  = slot_q;
        r.nxt  = (slot_q < NUM_SLOTS - 1) ? slot_q + 2'd1 : 2'd0;
        slot_q = r.nxt;

        r.fill  = 1'b0;
        r.fline = '0;
        if (scan_q >= sync_start && scan_q < sync_end)
        begin
            r.kind  = vlss_pkg::KIND_VSYNC;
            r.words = vlss_pkg::BLANK_WORDS;
        end
        else if (scan_q < blank_end)
        begin
            r.kind  = vlss_pkg::KIND_BLANK;
            r.words = vlss_pkg::BLANK_WORDS;
        end
        else
        begin
            r.kind  = vlss_pkg::KIND_ACTIVE;
            r.words = vlss_pkg::HEADER_WORDS + 12'(cfg_aw >> 1);
            r.fill  = 1'b1;
            r.fline = 11'(scan_q - blank_end);
        end

        // Wrap at or past the frame end; blink counted in frames
        r.fstart = 1'b0;
        inc = (scan_q + 1) & 32'h1FFF;
        if (inc >= total)
        begin
            inc      = 0;
            r.fstart = 1'b1;
            phase_q  = phase_q + 16'd1;
            if (phase_q >= cfg_blink)
            begin
                phase_q = '0;
                blink_q = ~blink_q;
            end
        end
        scan_q  = 13'(inc);
        r.blink = blink_q;
        return r;
    endfunction

    function automatic logic [31:0] reg_value(logic [2:0] idx);
        case (idx)
            vlss_pkg::REG_FRONT_PORCH: return 32'(cfg_fp);
            vlss_pkg::REG_SYNC:        return 32'(cfg_sw);
            vlss_pkg::REG_BACK_PORCH:  return 32'(cfg_bp);
            vlss_pkg::REG_ACTIVE:      return 32'(cfg_al);
            vlss_pkg::REG_WIDTH:       return 32'(cfg_aw);
            vlss_pkg::REG_BLINK:       return 32'(cfg_blink);
            default:                   return '0;
        endcase
    endfunction

    // Result checker
    always @(posedge clk)
    begin
        line_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_lines.size() == 0)
                report_mismatch("result with no pending line event");
            else
            begin
                want = pending_lines.pop_front();
                check_value("finished_slot",  finished_slot,  want.fin);
                check_value("next_slot",      next_slot,      want.nxt);
                check_value("line_kind",      line_kind,      want.kind);
                check_value("transfer_words", transfer_words, want.words);
                check_value("fill_request",   fill_request,   want.fill);
                check_value("fill_line",      fill_line,      want.fline);
                check_value("frame_start",    frame_start,    want.fstart);
                check_value("blink_level",    blink_level,    want.blink);
            end
        end
    end

    // APB read with setup and access phases, then the bus returns to idle
    task automatic read_reg(logic [2:0] idx, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data    = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // APB write, then read back defined registers
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            vlss_pkg::REG_FRONT_PORCH: cfg_fp    = value[9:0];
            vlss_pkg::REG_SYNC:        cfg_sw    = value[9:0];
            vlss_pkg::REG_BACK_PORCH:  cfg_bp    = value[9:0];
            vlss_pkg::REG_ACTIVE:      cfg_al    = value[10:0];
            vlss_pkg::REG_WIDTH:       cfg_aw    = value[11:0];
            vlss_pkg::REG_BLINK:       cfg_blink = value[15:0];
            default:                   ;
        endcase
        @(posedge clk);
        if (idx <= vlss_pkg::REG_BLINK)
        begin
            read_reg(idx, rd);
            check_value($sformatf("readback of register %0d", idx), rd, reg_value(idx));
        end
    endtask

    // Present one request, honoring the sender idle rate
    task automatic send_line_event(logic done);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        line_done <= done;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (done)
            pending_lines.push_back(advance_line());
    endtask

    // Stop sending and let every result come out
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_lines.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_idle_mode(int mode);
        case (mode)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 25; recv_stall_pct = 25; end
        endcase
    endtask

    function automatic logic [31:0] pick_value(int unsigned top, int unsigned near_top);
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'(top);
            default: return 32'($urandom_range(near_top));
        endcase
    endfunction

    // Reset values and the first lines after reset
    task automatic test_reset_state();
        logic [31:0] rd;
        for (int i = 0; i <= vlss_pkg::REG_BLINK; i++)
        begin
            read_reg(3'(i), rd);
            check_value($sformatf("reset value of register %0d", i), rd, reg_value(3'(i)));
        end
        send_line_event(1'b1);
        send_line_event(1'b0);
        send_line_event(1'b1);
        send_line_event(1'b1);
        wait_for_drain();
    endtask

    // Short frame touching sync, porch, active lines, wrap and blink toggle
    task automatic test_line_classes();
        write_reg(vlss_pkg::REG_FRONT_PORCH, 32'd2);
        write_reg(vlss_pkg::REG_SYNC,        32'd2);
        write_reg(vlss_pkg::REG_BACK_PORCH,  32'd1);
        write_reg(vlss_pkg::REG_ACTIVE,      32'd2);
        write_reg(vlss_pkg::REG_BLINK,       32'd1);
        repeat (9) send_line_event(1'b1);
        wait_for_drain();
    endtask

    // Zero total and zero blink period: every line wraps and toggles
    task automatic test_zero_total();
        write_reg(vlss_pkg::REG_FRONT_PORCH, 32'd0);
        write_reg(vlss_pkg::REG_SYNC,        32'd0);
        write_reg(vlss_pkg::REG_BACK_PORCH,  32'd0);
        write_reg(vlss_pkg::REG_ACTIVE,      32'd0);
        write_reg(vlss_pkg::REG_BLINK,       32'd0);
        repeat (4) send_line_event(1'b1);
        wait_for_drain();
    endtask

    // Widest line, narrow widths, oversized writes and dropped spare writes
    task automatic test_field_extremes();
        write_reg(vlss_pkg::REG_ACTIVE, 32'hFFFF_FFFF);
        write_reg(vlss_pkg::REG_WIDTH,  32'hFFFF_FFFF);
        write_reg(vlss_pkg::REG_BLINK,  32'hFFFF_FFFF);
        repeat (2) send_line_event(1'b1);
        wait_for_drain();
        write_reg(vlss_pkg::REG_WIDTH, 32'd0);
        send_line_event(1'b1);
        wait_for_drain();
        write_reg(vlss_pkg::REG_WIDTH, 32'd1);
        write_reg(REG_SPARE_A, 32'h0000_0155);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        send_line_event(1'b1);
        send_line_event(1'b0);
        wait_for_drain();
    endtask

    // Sender holds off mid-stream until the output side is empty
    task automatic test_drain_pause();
        write_reg(vlss_pkg::REG_FRONT_PORCH, 32'd1);
        write_reg(vlss_pkg::REG_SYNC,        32'd1);
        write_reg(vlss_pkg::REG_BACK_PORCH,  32'd2);
        write_reg(vlss_pkg::REG_ACTIVE,      32'd3);
        write_reg(vlss_pkg::REG_WIDTH,       32'd100);
        write_reg(vlss_pkg::REG_BLINK,       32'd2);
        set_idle_mode(2);
        repeat (20) send_line_event(1'b1);
        wait_for_drain();
        repeat (20) send_line_event($urandom_range(9) != 0);
        wait_for_drain();
    endtask

    // Random timing settings, cycling through the idle modes
    task automatic test_random_timing();
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            write_reg(vlss_pkg::REG_FRONT_PORCH, pick_value(1023, 3)  | ($urandom << 16));
            write_reg(vlss_pkg::REG_SYNC,        pick_value(1023, 3)  | ($urandom << 16));
            write_reg(vlss_pkg::REG_BACK_PORCH,  pick_value(1023, 3)  | ($urandom << 16));
            write_reg(vlss_pkg::REG_ACTIVE,      pick_value(2047, 6)  | ($urandom << 16));
            write_reg(vlss_pkg::REG_WIDTH,       pick_value(4095, 4095) | ($urandom << 16));
            write_reg(vlss_pkg::REG_BLINK,       pick_value(65535, 4));
            set_idle_mode(phase % 4);
            repeat (PHASE_LINES) send_line_event($urandom_range(9) != 0);
            wait_for_drain();
        end
        set_idle_mode(0);
    endtask

    // Main sequence
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_line_classes();
        test_zero_total();
        test_field_extremes();
        test_drain_pause();
        test_random_timing();
        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/vlss_pkg.sv
hw/rtl/video_line_slot_sequencer_core.sv
tb/tb.sv
